>>> sv/tttrdec_pkg.sv
// ----------------------------------------------------------------------------
// TTTR record decoder package
// Widths, format codes, register indexes and overflow wrap values shared by
// the decoder, its stream interfaces and its checker.
// ----------------------------------------------------------------------------
package tttrdec_pkg;

	// Time arithmetic is carried out modulo 2^TIME_W.
	localparam int TIME_W     = 64;
	localparam int HALF_W     = 32;
	localparam int HI_W       = TIME_W - HALF_W;
	localparam int OUT_TS_W   = 64;

	localparam int REC_W      = 32;
	localparam int CH_W       = 7;
	localparam int FMT_W      = 3;
	localparam int SYNC_W     = 40;
	localparam int BIN_W      = 16;
	localparam int DTIME_W    = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	// Record format codes.
	localparam logic [FMT_W-1:0] FMT_PT2V2 = 3'd0;
	localparam logic [FMT_W-1:0] FMT_PT3V2 = 3'd1;
	localparam logic [FMT_W-1:0] FMT_HT2V1 = 3'd2;
	localparam logic [FMT_W-1:0] FMT_HT2V2 = 3'd3;
	localparam logic [FMT_W-1:0] FMT_HT3V1 = 3'd4;
	localparam logic [FMT_W-1:0] FMT_HT3V2 = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_RES       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [FMT_W-1:0]  RST_RECORD_FORMAT = FMT_HT3V2;
	localparam logic [SYNC_W-1:0] RST_SYNC_INTERVAL = '0;
	localparam logic [BIN_W-1:0]  RST_BIN_RES       = 16'd1;
	localparam logic [CH_W-1:0]   RST_CHANNEL_COUNT = 7'd4;

	// Overflow channel codes.
	localparam logic [3:0] CH4_OVERFLOW = 4'hF;
	localparam logic [5:0] CH6_OVERFLOW = 6'h3F;

	// Overflow wrap values.
	localparam logic [TIME_W-1:0] WRAP_PT2   = TIME_W'(210698240);
	localparam logic [TIME_W-1:0] WRAP_PT3   = TIME_W'(65536);
	localparam logic [TIME_W-1:0] WRAP_HT2V1 = TIME_W'(33552000);
	localparam logic [TIME_W-1:0] WRAP_HT2V2 = TIME_W'(33554432);
	localparam logic [TIME_W-1:0] WRAP_HT3   = TIME_W'(1024);
	localparam int HT2V2_SHIFT = 25;
	localparam int HT3_SHIFT   = 10;

endpackage

>>> sv/tttrdec_rec_if.sv
// ----------------------------------------------------------------------------
// TTTR record stream interface
// Valid/ready channel carrying one raw 32-bit record per beat.
// ----------------------------------------------------------------------------
interface tttrdec_rec_if;
	import tttrdec_pkg::*;

	logic             valid;
	logic             ready;
	logic [REC_W-1:0] raw_record;

	modport source (output valid, output raw_record, input ready);
	modport sink (input valid, input raw_record, output ready);
endinterface

>>> sv/tttrdec_res_if.sv
// ----------------------------------------------------------------------------
// TTTR result stream interface
// Valid/ready channel carrying one decoded event (channel and time) per beat.
// ----------------------------------------------------------------------------
interface tttrdec_res_if;
	import tttrdec_pkg::*;

	logic                valid;
	logic                ready;
	logic [CH_W-1:0]     channel_index;
	logic [OUT_TS_W-1:0] timestamp_ps;

	modport source (output valid, output channel_index, output timestamp_ps, input ready);
	modport sink (input valid, input channel_index, input timestamp_ps, output ready);
endinterface

>>> sv/tttr_record_timestamp_decoder_unit.sv
// ----------------------------------------------------------------------------
// TTTR record timestamp decoder
// Pipeline: an accepted record beat passes through registers s1, s2, s3 and
// s4, and s4 drives the result port.
// Throughput: one record per cycle while the result port does not stall; the
// 64-bit overflow accumulator adder is the only feedback path.
// Reset: arst_n clears all stage valids and the accumulator and loads the
// configuration registers with their default values; beats in flight are lost.
// ----------------------------------------------------------------------------
module tttr_record_timestamp_decoder_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	tttrdec_rec_if.sink                           rec,
	tttrdec_res_if.source                         res,
	input  logic                                  cfg_we,
	input  logic [tttrdec_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tttrdec_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tttrdec_pkg::*;

	// The pipeline has four stages:
	//   s1  the accepted raw record.
	//   s2  the decoded record: channel, accumulator plus time field, dtime.
	//       Overflow records update the accumulator on the way into s2 and
	//       never occupy a slot beyond s1, as do markers and ignored records.
	//   s3  partial products of the T3 time, or the finished T2 time.
	//   s4  the result register driving the result port.
	// Each stage moves on when it is empty or when the stage after it moves,
	// so a stalled result holds the pipeline while bubbles are squeezed out.

	// Configuration registers.
	logic [FMT_W-1:0]  record_format_q;
	logic [SYNC_W-1:0] sync_interval_q;
	logic [BIN_W-1:0]  bin_res_q;
	logic [CH_W-1:0]   channel_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_format_q <= RST_RECORD_FORMAT;
			sync_interval_q <= RST_SYNC_INTERVAL;
			bin_res_q       <= RST_BIN_RES;
			channel_count_q <= RST_CHANNEL_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RECORD_FORMAT: record_format_q <= cfg_data[FMT_W-1:0];
				REG_SYNC_INTERVAL: sync_interval_q <= cfg_data[SYNC_W-1:0];
				REG_BIN_RES:       bin_res_q       <= cfg_data[BIN_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CH_W-1:0];
				default:           record_format_q <= record_format_q;
			endcase
		end
	end

	// Stage valids and the per-stage advance terms.
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4    = !v_s4 || res.ready;
	assign adv_s3    = !v_s3 || adv_s4;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign rec.ready = adv_s1;

	// Stage 1: the raw record.
	logic [REC_W-1:0] raw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= rec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && rec.valid) begin
			raw_s1 <= rec.raw_record;
		end
	end

	// Decode of the record held in stage 1. The accumulator is read here, so
	// every record sees the overflows of all the records before it.
	logic [TIME_W-1:0]  acc_q;
	logic               emit;
	logic [TIME_W-1:0]  wrap_inc;
	logic [TIME_W-1:0]  time_fld;
	logic [DTIME_W-1:0] dtime_fld;
	logic [CH_W-1:0]    chan;
	logic               is_t3;
	logic               is_pt2;
	logic               is_half;
	logic [3:0]         ch4;
	logic [5:0]         ch6;
	logic               special;
	logic [24:0]        ht2_tag;
	logic [9:0]         ht3_nsync;

	assign ch4       = raw_s1[31:28];
	assign ch6       = raw_s1[30:25];
	assign special   = raw_s1[31];
	assign ht2_tag   = raw_s1[24:0];
	assign ht3_nsync = raw_s1[9:0];

	always_comb begin
		emit      = 1'b0;
		wrap_inc  = '0;
		time_fld  = '0;
		dtime_fld = '0;
		chan      = '0;
		is_t3     = 1'b0;
		is_pt2    = 1'b0;
		is_half   = 1'b0;
		unique case (record_format_q)
			FMT_PT2V2: begin
				if (ch4 == CH4_OVERFLOW) begin
					// Only an overflow with a zero low nibble advances time.
					if (raw_s1[3:0] == 4'd0) begin
						wrap_inc = WRAP_PT2;
					end
				end else begin
					emit     = 1'b1;
					chan     = CH_W'(ch4);
					time_fld = TIME_W'(raw_s1[27:0]);
					is_pt2   = 1'b1;
				end
			end
			FMT_PT3V2: begin
				if (ch4 == CH4_OVERFLOW) begin
					if (raw_s1[27:16] == 12'd0) begin
						wrap_inc = WRAP_PT3;
					end
				end else begin
					emit      = 1'b1;
					chan      = CH_W'(ch4);
					time_fld  = TIME_W'(raw_s1[15:0]);
					dtime_fld = DTIME_W'(raw_s1[27:16]);
					is_t3     = 1'b1;
				end
			end
			FMT_HT2V1, FMT_HT2V2: begin
				if (special && ch6 == CH6_OVERFLOW) begin
					if (record_format_q == FMT_HT2V1) begin
						wrap_inc = WRAP_HT2V1;
					end else if (ht2_tag == 25'd0) begin
						wrap_inc = WRAP_HT2V2;
					end else begin
						wrap_inc = TIME_W'({ht2_tag, {HT2V2_SHIFT{1'b0}}});
					end
				end else if (!special || ch6 == 6'd0) begin
					// A special record with channel zero is the sync.
					emit     = 1'b1;
					chan     = special ? channel_count_q : CH_W'(ch6);
					time_fld = TIME_W'(ht2_tag);
					is_half  = (record_format_q == FMT_HT2V1);
				end
			end
			FMT_HT3V1, FMT_HT3V2: begin
				if (special) begin
					if (ch6 == CH6_OVERFLOW) begin
						if (record_format_q == FMT_HT3V1 || ht3_nsync == 10'd0) begin
							wrap_inc = WRAP_HT3;
						end else begin
							wrap_inc = TIME_W'({ht3_nsync, {HT3_SHIFT{1'b0}}});
						end
					end
				end else begin
					emit      = 1'b1;
					chan      = CH_W'(ch6);
					time_fld  = TIME_W'(ht3_nsync);
					dtime_fld = raw_s1[24:10];
					is_t3     = 1'b1;
				end
			end
			default: begin
				// Unused format codes: the record is dropped.
				emit = 1'b0;
			end
		endcase
	end

	// Stage 2: accumulator update and the decoded record.
	logic [TIME_W-1:0]  base_s2;
	logic [DTIME_W-1:0] dtime_s2;
	logic [CH_W-1:0]    chan_s2;
	logic               t3_s2, pt2_s2, half_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else if (adv_s2) begin
			v_s2 <= v_s1 && emit;
			if (v_s1) begin
				acc_q <= acc_q + wrap_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			base_s2  <= acc_q + time_fld;
			dtime_s2 <= dtime_fld;
			chan_s2  <= chan;
			t3_s2    <= is_t3;
			pt2_s2   <= is_pt2;
			half_s2  <= is_half;
		end
	end

	// Stage 3: the T3 time (base * sync interval + dtime * bin) is split into
	// 32-bit partial products; the cross terms only need their low bits
	// because the product is kept modulo 2^TIME_W. T2 times finish here.
	logic [HALF_W-1:0]            a_lo, b_lo;
	logic [HI_W-1:0]              a_hi;
	logic [SYNC_W-HALF_W-1:0]     b_hi;
	logic [2*HALF_W-1:0]          m_ll;
	logic [HALF_W+SYNC_W-HALF_W-1:0] m_lh;
	logic [HI_W+HALF_W-1:0]       m_hl;
	logic [DTIME_W+BIN_W-1:0]     m_db;
	logic [TIME_W-1:0]            t2_time;

	assign a_lo = base_s2[HALF_W-1:0];
	assign a_hi = base_s2[TIME_W-1:HALF_W];
	assign b_lo = sync_interval_q[HALF_W-1:0];
	assign b_hi = sync_interval_q[SYNC_W-1:HALF_W];
	assign m_ll = a_lo * b_lo;
	assign m_lh = a_lo * b_hi;
	assign m_hl = a_hi * b_lo;
	assign m_db = dtime_s2 * bin_res_q;

	always_comb begin
		if (pt2_s2) begin
			t2_time = {base_s2[TIME_W-3:0], 2'b00};
		end else if (half_s2) begin
			// Rounded half: the carry of the rounding never leaves the word.
			t2_time = (base_s2 >> 1) + TIME_W'(base_s2[0]);
		end else begin
			t2_time = base_s2;
		end
	end

	logic [TIME_W-1:0]        p_ll_s3;
	logic [HI_W-1:0]          p_lh_s3, p_hl_s3;
	logic [DTIME_W+BIN_W-1:0] p_db_s3;
	logic [TIME_W-1:0]        t2_s3;
	logic [CH_W-1:0]          chan_s3;
	logic                     t3_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			p_ll_s3 <= m_ll[TIME_W-1:0];
			p_lh_s3 <= m_lh[HI_W-1:0];
			p_hl_s3 <= m_hl[HI_W-1:0];
			p_db_s3 <= m_db;
			t2_s3   <= t2_time;
			chan_s3 <= chan_s2;
			t3_s3   <= t3_s2;
		end
	end

	// Stage 4: partial products summed into the result register.
	logic [HI_W-1:0]   cross_sum;
	logic [TIME_W-1:0] t3_time;

	assign cross_sum = p_lh_s3 + p_hl_s3;
	assign t3_time   = p_ll_s3 + {cross_sum, {HALF_W{1'b0}}} + TIME_W'(p_db_s3);

	logic [TIME_W-1:0] ts_s4;
	logic [CH_W-1:0]   chan_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && v_s3) begin
			ts_s4   <= t3_s3 ? t3_time : t2_s3;
			chan_s4 <= chan_s3;
		end
	end

	assign res.valid         = v_s4;
	assign res.channel_index = chan_s4;
	assign res.timestamp_ps  = OUT_TS_W'(ts_s4);

endmodule

>>> sv/tttrdec_checker.sv
// ----------------------------------------------------------------------------
// TTTR record decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tttrdec_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [tttrdec_pkg::CH_W-1:0]     out_channel,
	input logic [tttrdec_pkg::OUT_TS_W-1:0] out_time
);
	import tttrdec_pkg::*;

	// A stalled result beat keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(out_time))
	else $error("result beat changed while stalled");

	// With the result register empty nothing can block the record port.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
	else $error("record port stalled with an empty result register");

	// A result taken this cycle frees the whole pipeline.
	a_ready_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
	else $error("record port stalled while a result beat was taken");

	// No result appears in the first cycle after reset is released.
	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
	else $error("result beat straight after reset");

endmodule

bind tttr_record_timestamp_decoder_unit tttrdec_checker u_tttrdec_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (rec.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.out_channel (res.channel_index),
	.out_time    (res.timestamp_ps)
);
